[rtl/multi_motor_chunk_queue_macros.svh]
// Assertion macros shared by the chunk queue RTL.
`ifndef MULTI_MOTOR_CHUNK_QUEUE_MACROS_SVH
`define MULTI_MOTOR_CHUNK_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMCQ_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MMCQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

[rtl/mmcq_pkg.sv]
// Constants and types of the multi-motor chunk queue.
`default_nettype none
package mmcq_pkg;

   localparam int MOTORS     = 4;
   localparam int MIDX_W     = (MOTORS > 1) ? $clog2(MOTORS) : 1;
   localparam int IDX_W      = 8;
   localparam int RING_DEPTH = 256;
   localparam int VEL_W      = 8;
   localparam int SLOT_W     = VEL_W + 1;
   localparam int ROW_W      = MOTORS * SLOT_W;
   localparam int MOTOR_W    = 2;
   localparam int MASK_W     = 4;
   localparam int MODE_W     = 4;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;

   localparam logic [IDX_W-1:0] NO_SELECTION = 8'hFF;
   localparam logic [VEL_W-1:0] DIR_FORWARD  = 8'd1;

   typedef enum logic [MODE_W-1:0] {
      MODE_ENQUEUE     = 4'd0,
      MODE_FETCH       = 4'd1,
      MODE_ADVANCE     = 4'd2,
      MODE_CLEAR_ALL   = 4'd3,
      MODE_CLEAR_MOTOR = 4'd4,
      MODE_SKIP        = 4'd5,
      MODE_SYNC_MASK   = 4'd6,
      MODE_SYNC_PAIR   = 4'd7,
      MODE_QUERY       = 4'd8
   } mode_type;

endpackage
`default_nettype wire

[rtl/multi_motor_chunk_queue.sv]
// Multi-motor step-chunk queue: per-motor rings in one shared row memory.
// Enqueue and fetch read the row, then write it back; mask sync finds the minimum, then aligns.
// A new transaction is accepted only once the result of the last one has been registered.
// A clear sweeps all 256 rows one per cycle; a pending result stalls the next one.
// Reset is synchronous; a sweep then zeroes the rows while req_tready is low.
`default_nettype none
`include "multi_motor_chunk_queue_macros.svh"
module multi_motor_chunk_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // motor, motor_b, motor_mask, direction, velocity, skip_steps,
   // motor_blocked, probe_index, zero fill
   input  logic [mmcq_pkg::REQ_DATA_W-1:0]     req_tdata,
   // mode
   input  logic [mmcq_pkg::MODE_W-1:0]         req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // accepted, fetched_velocity, fetched_reverse, motor_idle, all_idle,
   // mask_idle, queue_full, free_slots, sync_min, write_position,
   // read_position, slots_ahead, zero fill
   output logic [mmcq_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import mmcq_pkg::*;

   typedef enum logic [6:0] {
      S_INIT   = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_EXEC   = 7'b0000100,
      S_MODIFY = 7'b0001000,
      S_ALIGN  = 7'b0010000,
      S_CLEAR  = 7'b0100000,
      S_RESULT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // Request payload.
   mode_type           mode_ff;
   logic [MOTOR_W-1:0] motor_ff, motor_b_ff;
   logic [MASK_W-1:0]  mask_ff;
   logic [7:0]         dir_ff, vel_ff, skip_ff, probe_ff;
   logic               blocked_ff;

   // Queue state.
   logic [IDX_W-1:0]   reader_ff, reader_in;
   logic [IDX_W-1:0]   writer_ff [MOTORS];
   logic [IDX_W-1:0]   writer_in [MOTORS];
   logic [VEL_W-1:0]   cur_vel_ff [MOTORS];
   logic [VEL_W-1:0]   cur_vel_in [MOTORS];
   logic [MOTORS-1:0]  cur_rev_ff, cur_rev_in;
   logic [MOTORS-1:0]  cur_idle_ff, cur_idle_in;
   logic               accepted_ff, accepted_in;
   logic [IDX_W-1:0]   min_ff, min_in;

   // Clearing sweep.
   logic [IDX_W:0]     sweep_ff, sweep_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   pend_addr_ff, pend_addr_in;
   logic               clear_all_ff, clear_all_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Row memory: one row per ring position, one slot per motor.
   logic [ROW_W-1:0]   mem [RING_DEPTH];
   logic [ROW_W-1:0]   mem_rdata_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr, mem_raddr;
   logic [ROW_W-1:0]   mem_wdata;

   logic               m_valid, mb_valid;
   logic [MIDX_W-1:0]  m_idx, mb_idx;
   logic [MOTORS-1:0]  sel;
   logic [IDX_W-1:0]   free_cnt [MOTORS];
   logic [IDX_W-1:0]   sel_min;
   logic [VEL_W-1:0]   rd_vel;
   logic               rd_rev;
   logic [ROW_W-1:0]   row_vel_cleared;
   logic               req_fire;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign m_valid  = int'(motor_ff) < MOTORS;
   assign mb_valid = int'(motor_b_ff) < MOTORS;
   assign m_idx    = MIDX_W'(motor_ff);
   assign mb_idx   = MIDX_W'(motor_b_ff);
   assign sel      = MOTORS'(mask_ff);

   assign rd_vel = mem_rdata_ff[m_idx*SLOT_W +: VEL_W];
   assign rd_rev = mem_rdata_ff[m_idx*SLOT_W + VEL_W];

   always_comb begin
      row_vel_cleared = mem_rdata_ff;
      row_vel_cleared[m_idx*SLOT_W +: VEL_W] = '0;
   end

   // Free counts and the smallest one among the selected motors.
   always_comb begin
      sel_min = NO_SELECTION;
      for (int i = 0; i < MOTORS; i++) begin
         free_cnt[i] = reader_ff - writer_ff[i] - 8'd1;
         if (sel[i] && (free_cnt[i] < sel_min)) begin
            sel_min = free_cnt[i];
         end
      end
   end

   always_comb begin
      logic [ROW_W-1:0] row_new;
      logic             full_flag;
      row_new      = mem_rdata_ff;
      full_flag    = 1'b0;
      state_in     = state_ff;
      reader_in    = reader_ff;
      writer_in    = writer_ff;
      cur_vel_in   = cur_vel_ff;
      cur_rev_in   = cur_rev_ff;
      cur_idle_in  = cur_idle_ff;
      accepted_in  = accepted_ff;
      min_in       = min_ff;
      sweep_in     = sweep_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      clear_all_in = clear_all_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = pend_addr_ff;
      mem_wdata    = '0;
      mem_raddr    = sweep_ff[IDX_W-1:0];

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_INIT, S_CLEAR: begin
            // Reads run one row ahead of the write back.
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pend_addr_ff;
               mem_wdata = clear_all_ff ? '0 : row_vel_cleared;
            end
            if (!sweep_ff[IDX_W]) begin
               mem_raddr    = sweep_ff[IDX_W-1:0];
               pend_in      = 1'b1;
               pend_addr_in = sweep_ff[IDX_W-1:0];
               sweep_in     = sweep_ff + (IDX_W+1)'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = (state_ff == S_INIT) ? S_IDLE : S_RESULT;
               end
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            accepted_in = 1'b0;
            state_in    = S_RESULT;
            case (mode_ff)
               MODE_ENQUEUE: begin
                  mem_raddr = writer_ff[m_idx];
                  state_in  = S_MODIFY;
               end
               MODE_FETCH: begin
                  mem_raddr = reader_ff;
                  state_in  = S_MODIFY;
               end
               MODE_ADVANCE: begin
                  for (int i = 0; i < MOTORS; i++) begin
                     if (writer_ff[i] == reader_ff) begin
                        writer_in[i] = reader_ff + 8'd1;
                     end
                  end
                  reader_in = reader_ff + 8'd1;
               end
               MODE_CLEAR_ALL: begin
                  for (int i = 0; i < MOTORS; i++) begin
                     writer_in[i]  = reader_ff;
                     cur_vel_in[i] = '0;
                  end
                  cur_rev_in   = '0;
                  cur_idle_in  = '1;
                  clear_all_in = 1'b1;
                  sweep_in     = '0;
                  pend_in      = 1'b0;
                  state_in     = S_CLEAR;
               end
               MODE_CLEAR_MOTOR: begin
                  if (m_valid) begin
                     writer_in[m_idx]   = reader_ff;
                     cur_vel_in[m_idx]  = '0;
                     cur_rev_in[m_idx]  = 1'b0;
                     cur_idle_in[m_idx] = 1'b1;
                     clear_all_in       = 1'b0;
                     sweep_in           = '0;
                     pend_in            = 1'b0;
                     state_in           = S_CLEAR;
                  end
               end
               MODE_SKIP: begin
                  if (m_valid) begin
                     writer_in[m_idx] = reader_ff + skip_ff;
                  end
               end
               MODE_SYNC_MASK: begin
                  min_in   = sel_min;
                  state_in = S_ALIGN;
               end
               MODE_SYNC_PAIR: begin
                  if (m_valid && mb_valid) begin
                     if (free_cnt[m_idx] < free_cnt[mb_idx]) begin
                        writer_in[mb_idx] = writer_ff[m_idx];
                     end else begin
                        writer_in[m_idx] = writer_ff[mb_idx];
                     end
                  end
               end
               default: begin
                  state_in = S_RESULT;
               end
            endcase
         end
         S_ALIGN: begin
            for (int i = 0; i < MOTORS; i++) begin
               if (sel[i]) begin
                  writer_in[i] = reader_ff - min_ff - 8'd1;
               end
            end
            state_in = S_RESULT;
         end
         S_MODIFY: begin
            if (mode_ff == MODE_ENQUEUE) begin
               full_flag = (writer_ff[m_idx] + 8'd1) == reader_ff;
               if (m_valid && !blocked_ff && !full_flag) begin
                  row_new[m_idx*SLOT_W +: VEL_W] = vel_ff;
                  row_new[m_idx*SLOT_W + VEL_W]  = (dir_ff != DIR_FORWARD);
                  mem_we           = 1'b1;
                  mem_waddr        = writer_ff[m_idx];
                  mem_wdata        = row_new;
                  writer_in[m_idx] = writer_ff[m_idx] + 8'd1;
                  accepted_in      = 1'b1;
               end
            end else if (m_valid) begin
               if (writer_ff[m_idx] == reader_ff) begin
                  cur_vel_in[m_idx]  = '0;
                  cur_rev_in[m_idx]  = 1'b0;
                  cur_idle_in[m_idx] = 1'b1;
               end else begin
                  // The fetched slot keeps its direction flag.
                  cur_vel_in[m_idx]  = rd_vel;
                  cur_rev_in[m_idx]  = rd_rev;
                  cur_idle_in[m_idx] = 1'b0;
                  mem_we             = 1'b1;
                  mem_waddr          = reader_ff;
                  mem_wdata          = row_vel_cleared;
               end
            end
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               full_flag    = m_valid && ((writer_ff[m_idx] + 8'd1) == reader_ff);
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00,
                               probe_ff - reader_ff,
                               reader_ff,
                               m_valid ? writer_ff[m_idx] : 8'd0,
                               sel_min,
                               m_valid ? free_cnt[m_idx] : 8'd0,
                               full_flag,
                               &(cur_idle_ff | ~sel),
                               &cur_idle_ff,
                               m_valid ? cur_idle_ff[m_idx] : 1'b1,
                               m_valid ? cur_rev_ff[m_idx] : 1'b0,
                               m_valid ? cur_vel_ff[m_idx] : 8'd0,
                               accepted_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         reader_ff    <= '0;
         for (int i = 0; i < MOTORS; i++) begin
            writer_ff[i]  <= '0;
            cur_vel_ff[i] <= '0;
         end
         cur_rev_ff   <= '0;
         cur_idle_ff  <= '1;
         accepted_ff  <= 1'b0;
         min_ff       <= '0;
         sweep_ff     <= '0;
         pend_ff      <= 1'b0;
         pend_addr_ff <= '0;
         clear_all_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         reader_ff    <= reader_in;
         writer_ff    <= writer_in;
         cur_vel_ff   <= cur_vel_in;
         cur_rev_ff   <= cur_rev_in;
         cur_idle_ff  <= cur_idle_in;
         accepted_ff  <= accepted_in;
         min_ff       <= min_in;
         sweep_ff     <= sweep_in;
         pend_ff      <= pend_in;
         pend_addr_ff <= pend_addr_in;
         clear_all_ff <= clear_all_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (req_fire) begin
         mode_ff    <= mode_type'(req_tuser);
         motor_ff   <= req_tdata[1:0];
         motor_b_ff <= req_tdata[3:2];
         mask_ff    <= req_tdata[7:4];
         dir_ff     <= req_tdata[15:8];
         vel_ff     <= req_tdata[23:16];
         skip_ff    <= req_tdata[31:24];
         blocked_ff <= req_tdata[32];
         probe_ff   <= req_tdata[40:33];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

   `MMCQ_ASSERT_NEXT(a_accept_starts_exec, req_fire, state_ff == S_EXEC)
   `MMCQ_ASSERT_SAME(a_write_phase, mem_we, (state_ff & (S_MODIFY | S_CLEAR | S_INIT)) != '0)
   `MMCQ_ASSERT_SAME(a_accept_only_enqueue, state_ff == S_RESULT && accepted_ff,
                     mode_ff == MODE_ENQUEUE && m_valid)
   `MMCQ_ASSERT_NEXT(a_reader_moves_on_advance,
                     !(state_ff == S_EXEC && mode_ff == MODE_ADVANCE), $stable(reader_ff))

endmodule
`default_nettype wire

[dv/multi_motor_chunk_queue_tb.sv]
// Self-checking testbench for the multi-motor step-chunk queue.
`timescale 1ns / 100ps
module multi_motor_chunk_queue_tb;
   import mmcq_pkg::*;

   localparam int RANDOM_OPS  = 1350;
   localparam int STALL_LIMIT = 3000;
   localparam logic [MODE_W-1:0] MODE_LAST_CODE = '1;

   typedef struct packed {
      logic [7:0] probe_index;
      logic       motor_blocked;
      logic [7:0] skip_steps;
      logic [7:0] velocity;
      logic [7:0] direction;
      logic [3:0] motor_mask;
      logic [1:0] motor_b;
      logic [1:0] motor;
   } chunk_fields_t;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      chunk_fields_t     f;
   } chunk_op_t;

   typedef struct packed {
      logic [7:0] slots_ahead;
      logic [7:0] read_position;
      logic [7:0] write_position;
      logic [7:0] sync_min;
      logic [7:0] free_slots;
      logic       queue_full;
      logic       mask_idle;
      logic       all_idle;
      logic       motor_idle;
      logic       fetched_reverse;
      logic [7:0] fetched_velocity;
      logic       accepted;
   } chunk_status_t;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [MODE_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   multi_motor_chunk_queue u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Shadow copy of the queue state.
   logic [7:0] slot_vel [RING_DEPTH*MOTORS];
   logic       slot_rev [RING_DEPTH*MOTORS];
   logic [7:0] wr_idx [MOTORS];
   logic [7:0] rd_idx;
   logic [7:0] cur_vel [MOTORS];
   logic       cur_rev [MOTORS];
   logic       cur_idle [MOTORS];

   chunk_op_t     op_backlog[$];
   chunk_status_t expected_status[$];
   chunk_op_t     op_on_bus;
   int            ops_accepted = 0;
   int            total_ops = 1;
   int            mismatches = 0;
   int            stall_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] free_slots_of(int m);
      return 8'(rd_idx - wr_idx[m] - 8'd1);
   endfunction

   function automatic void make_motor_idle(int m);
      cur_vel[m]  = '0;
      cur_rev[m]  = 1'b0;
      cur_idle[m] = 1'b1;
   endfunction

   function automatic chunk_status_t apply_chunk_op(chunk_op_t op);
      chunk_status_t st;
      logic [7:0]    lowest;
      logic [9:0]    s;
      int            m;
      int            mb;
      st = '0;
      m  = op.f.motor;
      mb = op.f.motor_b;
      case (op.mode)
         MODE_ENQUEUE: begin
            if (!op.f.motor_blocked && 8'(wr_idx[m] + 8'd1) != rd_idx) begin
               s = {wr_idx[m], op.f.motor};
               slot_vel[s] = op.f.velocity;
               slot_rev[s] = (op.f.direction != DIR_FORWARD);
               wr_idx[m]   = 8'(wr_idx[m] + 8'd1);
               st.accepted = 1'b1;
            end
         end
         MODE_FETCH: begin
            if (wr_idx[m] == rd_idx) begin
               make_motor_idle(m);
            end else begin
               s = {rd_idx, op.f.motor};
               cur_vel[m]  = slot_vel[s];
               cur_rev[m]  = slot_rev[s];
               cur_idle[m] = 1'b0;
               slot_vel[s] = '0;
            end
         end
         MODE_ADVANCE: begin
            for (int i = 0; i < MOTORS; i++)
               if (wr_idx[i] == rd_idx) wr_idx[i] = 8'(rd_idx + 8'd1);
            rd_idx = 8'(rd_idx + 8'd1);
         end
         MODE_CLEAR_ALL: begin
            for (int j = 0; j < RING_DEPTH*MOTORS; j++) begin
               slot_vel[j] = '0;
               slot_rev[j] = 1'b0;
            end
            for (int i = 0; i < MOTORS; i++) begin
               make_motor_idle(i);
               wr_idx[i] = rd_idx;
            end
         end
         MODE_CLEAR_MOTOR: begin
            // Direction flags survive a single-motor clear.
            for (int j = 0; j < RING_DEPTH; j++) slot_vel[j*MOTORS + m] = '0;
            make_motor_idle(m);
            wr_idx[m] = rd_idx;
         end
         MODE_SKIP: wr_idx[m] = 8'(rd_idx + op.f.skip_steps);
         MODE_SYNC_MASK: begin
            lowest = NO_SELECTION;
            for (int i = 0; i < MOTORS; i++)
               if (op.f.motor_mask[i] && free_slots_of(i) < lowest) lowest = free_slots_of(i);
            for (int i = 0; i < MOTORS; i++)
               if (op.f.motor_mask[i]) wr_idx[i] = 8'(rd_idx - lowest - 8'd1);
         end
         MODE_SYNC_PAIR: begin
            if (free_slots_of(m) < free_slots_of(mb)) wr_idx[mb] = wr_idx[m];
            else wr_idx[m] = wr_idx[mb];
         end
         default: ;
      endcase

      st.all_idle  = 1'b1;
      st.mask_idle = 1'b1;
      st.sync_min  = NO_SELECTION;
      for (int i = 0; i < MOTORS; i++) begin
         if (!cur_idle[i]) st.all_idle = 1'b0;
         if (op.f.motor_mask[i]) begin
            if (!cur_idle[i]) st.mask_idle = 1'b0;
            if (free_slots_of(i) < st.sync_min) st.sync_min = free_slots_of(i);
         end
      end
      st.fetched_velocity = cur_vel[m];
      st.fetched_reverse  = cur_rev[m];
      st.motor_idle       = cur_idle[m];
      st.queue_full       = (8'(wr_idx[m] + 8'd1) == rd_idx);
      st.free_slots       = free_slots_of(m);
      st.write_position   = wr_idx[m];
      st.read_position    = rd_idx;
      st.slots_ahead      = 8'(op.f.probe_index - rd_idx);
      return st;
   endfunction

   function automatic chunk_op_t make_op(logic [MODE_W-1:0] mode, logic [1:0] motor,
                                         logic [1:0] motor_b, logic [3:0] mask,
                                         logic [7:0] dir, logic [7:0] vel,
                                         logic [7:0] steps, logic blocked,
                                         logic [7:0] probe);
      chunk_op_t op;
      op.mode            = mode;
      op.f.motor         = motor;
      op.f.motor_b       = motor_b;
      op.f.motor_mask    = mask;
      op.f.direction     = dir;
      op.f.velocity      = vel;
      op.f.skip_steps    = steps;
      op.f.motor_blocked = blocked;
      op.f.probe_index   = probe;
      return op;
   endfunction

   function automatic chunk_op_t random_op(logic [MODE_W-1:0] mode, logic [1:0] motor);
      chunk_op_t op;
      op.mode            = mode;
      op.f.motor         = motor;
      op.f.motor_b       = 2'($urandom_range(0, 3));
      op.f.motor_mask    = 4'($urandom_range(0, 15));
      op.f.direction     = ($urandom_range(0, 1) == 0) ? DIR_FORWARD
                                                      : 8'($urandom_range(0, 255));
      op.f.velocity      = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
         0: op.f.skip_steps = 8'($urandom_range(250, 255));
         1: op.f.skip_steps = 8'($urandom_range(0, 3));
         default: op.f.skip_steps = 8'($urandom_range(0, 255));
      endcase
      op.f.motor_blocked = ($urandom_range(0, 4) == 0);
      op.f.probe_index   = 8'($urandom_range(0, 255));
      return op;
   endfunction

   function automatic int idle_percent(bit sender);
      int phase;
      phase = ops_accepted * 3 / total_ops;
      if (phase == 0) return sender ? 10 : 88;
      if (phase == 1) return sender ? 88 : 10;
      return 0;
   endfunction

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Request driver: predicts each transaction as it is accepted.
   always @(posedge clock) begin : drive_requests
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_status.push_back(apply_chunk_op(op_on_bus));
            ops_accepted <= ops_accepted + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (op_backlog.size() != 0 && $urandom_range(0, 99) >= idle_percent(1'b1)) begin
               op_on_bus = op_backlog.pop_front();
               req_tuser  <= op_on_bus.mode;
               req_tdata  <= REQ_DATA_W'(op_on_bus.f);
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor with random back-pressure.
   always @(posedge clock) begin : check_responses
      chunk_status_t got;
      chunk_status_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = chunk_status_t'(rsp_tdata[$bits(chunk_status_t)-1:0]);
            if (expected_status.size() == 0) begin
               $display("%0t: unexpected response transaction: expected none, actual %h",
                        $time, got);
               mismatches++;
            end else begin
               want = expected_status.pop_front();
               compare_field("accepted", want.accepted, got.accepted);
               compare_field("fetched_velocity", want.fetched_velocity, got.fetched_velocity);
               compare_field("fetched_reverse", want.fetched_reverse, got.fetched_reverse);
               compare_field("motor_idle", want.motor_idle, got.motor_idle);
               compare_field("all_idle", want.all_idle, got.all_idle);
               compare_field("mask_idle", want.mask_idle, got.mask_idle);
               compare_field("queue_full", want.queue_full, got.queue_full);
               compare_field("free_slots", want.free_slots, got.free_slots);
               compare_field("sync_min", want.sync_min, got.sync_min);
               compare_field("write_position", want.write_position, got.write_position);
               compare_field("read_position", want.read_position, got.read_position);
               compare_field("slots_ahead", want.slots_ahead, got.slots_ahead);
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= idle_percent(1'b0));
      end
   end

   always @(posedge clock) begin : count_stalls
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin : run_sequence
      int        goal;
      int        n;
      logic [1:0] focus;
      logic [1:0] m;
      chunk_op_t op;

      for (int j = 0; j < RING_DEPTH*MOTORS; j++) begin
         slot_vel[j] = '0;
         slot_rev[j] = 1'b0;
      end
      rd_idx = '0;
      for (int i = 0; i < MOTORS; i++) begin
         wr_idx[i] = '0;
         make_motor_idle(i);
      end

      // Directed part: field extremes, every operation and the corner cases.
      op_backlog.push_back(make_op(MODE_QUERY, 0, 0, 4'hF, 0, 0, 0, 0, 8'hFF));
      op_backlog.push_back(make_op(MODE_ENQUEUE, 0, 0, 4'h1, DIR_FORWARD, 8'hFF, 0, 0, 0));
      op_backlog.push_back(make_op(MODE_ENQUEUE, 0, 0, 4'h1, 8'h00, 8'h00, 0, 0, 0));
      op_backlog.push_back(make_op(MODE_ENQUEUE, 1, 0, 4'h2, 8'hFF, 8'hAA, 0, 1, 0));
      op_backlog.push_back(make_op(MODE_ENQUEUE, 3, 0, 4'h8, 8'h02, 8'h55, 0, 0, 8'h80));
      op_backlog.push_back(make_op(MODE_FETCH, 0, 0, 4'hF, 0, 0, 0, 0, 0));
      op_backlog.push_back(make_op(MODE_FETCH, 2, 0, 4'h4, 0, 0, 0, 0, 0));
      op_backlog.push_back(make_op(MODE_ADVANCE, 0, 0, 4'hF, 0, 0, 0, 0, 0));
      op_backlog.push_back(make_op(MODE_FETCH, 0, 0, 4'h1, 0, 0, 0, 0, 0));
      op_backlog.push_back(make_op(MODE_ADVANCE, 3, 0, 4'hF, 0, 0, 0, 0, 0));
      op_backlog.push_back(make_op(MODE_SKIP, 1, 0, 4'h2, 0, 0, 8'hFF, 0, 0));
      op_backlog.push_back(make_op(MODE_ENQUEUE, 1, 0, 4'h2, DIR_FORWARD, 8'h11, 0, 0, 0));
      op_backlog.push_back(make_op(MODE_SKIP, 2, 0, 4'h4, 0, 0, 8'h00, 0, 0));
      op_backlog.push_back(make_op(MODE_SYNC_PAIR, 1, 2, 4'h6, 0, 0, 0, 0, 0));
      op_backlog.push_back(make_op(MODE_SYNC_PAIR, 2, 2, 4'h4, 0, 0, 0, 0, 0));
      op_backlog.push_back(make_op(MODE_SKIP, 3, 0, 4'h8, 0, 0, 8'h10, 0, 0));
      op_backlog.push_back(make_op(MODE_SYNC_MASK, 0, 0, 4'h6, 0, 0, 0, 0, 0));
      op_backlog.push_back(make_op(MODE_SYNC_MASK, 0, 0, 4'h0, 0, 0, 0, 0, 0));
      op_backlog.push_back(make_op(MODE_SYNC_MASK, 3, 0, 4'hF, 0, 0, 0, 0, 0));
      op_backlog.push_back(make_op(MODE_LAST_CODE, 3, 3, 4'hF, 8'hFF, 8'hFF, 8'hFF, 1,
                                   8'hFF));
      op_backlog.push_back(make_op(MODE_CLEAR_MOTOR, 3, 0, 4'h8, 0, 0, 0, 0, 0));
      op_backlog.push_back(make_op(MODE_FETCH, 3, 0, 4'h8, 0, 0, 0, 0, 0));
      op_backlog.push_back(make_op(MODE_CLEAR_ALL, 0, 0, 4'hF, 0, 0, 0, 0, 0));
      op_backlog.push_back(make_op(MODE_QUERY, 0, 0, 4'h0, 0, 0, 0, 0, 0));
      op_backlog.push_back(make_op(MODE_ENQUEUE, 2, 3, 4'hF, 8'hFF, 8'hFF, 8'hFF, 0, 8'hFF));

      // Random part: mostly fill-and-drain runs on a focus motor, the rest noise.
      goal = op_backlog.size() + RANDOM_OPS;
      while (op_backlog.size() < goal) begin
         focus = 2'($urandom_range(0, 3));
         if ($urandom_range(0, 99) < 55) begin
            // Starting near full makes the later enqueues hit a full ring.
            if ($urandom_range(0, 3) == 0) begin
               op = random_op(MODE_SKIP, focus);
               op.f.skip_steps = 8'($urandom_range(250, 255));
               op_backlog.push_back(op);
            end
            n = $urandom_range(1, 8);
            repeat (n) begin
               m = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : focus;
               op = random_op(MODE_ENQUEUE, m);
               op.f.motor_blocked = ($urandom_range(0, 9) == 0);
               op_backlog.push_back(op);
            end
            n = $urandom_range(1, 6);
            repeat (n) begin
               op_backlog.push_back(random_op(MODE_FETCH, focus));
               op_backlog.push_back(random_op(MODE_ADVANCE, focus));
            end
         end else begin
            n = $urandom_range(1, 4);
            repeat (n)
               op_backlog.push_back(random_op(4'($urandom_range(0, 15)),
                                              2'($urandom_range(0, 3))));
         end
      end
      total_ops = op_backlog.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while ((op_backlog.size() != 0 || req_tvalid || expected_status.size() != 0)
             && stall_cycles < STALL_LIMIT)
         @(posedge clock);

      if (stall_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
      end else begin
         repeat (20) @(posedge clock);
         if (mismatches == 0)
            $display("Test completed successfully");
         else
            $display("Test completed with failures");
      end
      $finish;
   end

endmodule
